@@ rtl/mesh_node_adjacency_builder_macros.svh @@
// Assertion helpers used by the RTL datapath.
`ifndef MESH_NODE_ADJACENCY_BUILDER_MACROS_SVH
`define MESH_NODE_ADJACENCY_BUILDER_MACROS_SVH

// Condition holds at every rising clock edge outside reset.
`define MNAB_ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define MNAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequence violated");

`endif

@@ rtl/mnab_pkg.sv @@
package mnab_pkg;

  localparam int LIM_W = 17;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_LIMIT = 1'b1;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    KIND_LINK  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_NBR     = 3'd1,
    ST_ELEM_FULL  = 3'd2,
    ST_NODE_FULL  = 3'd3,
    ST_NODE_LIMIT = 3'd4,
    ST_TRUNC      = 3'd5,
    ST_Q_RANGE    = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] element;
    logic [11:0] node;
  } item_t;

  typedef struct packed {
    logic [11:0] neighbor;
    logic        last;
    logic [2:0]  status;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_L_RD, S_L_CHK, S_L_NCHK, S_PUSH,
    S_Q_CHK, S_Q_NF, S_Q_A, S_Q_EL, S_Q_EF, S_Q_B, S_Q_ND,
    S_Q_UNMARK, S_Q_CNT, S_Q_CEND, S_Q_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_L_RD, OP_L_WR_E, OP_L_WR_N, OP_PUSH,
    OP_Q_MARK, OP_Q_NF, OP_Q_RD_NEL, OP_Q_EL, OP_Q_EF, OP_Q_RD_ENL,
    OP_Q_ND, OP_Q_UNMARK, OP_Q_CNT, OP_Q_CEND, OP_Q_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    ld_st;
    status_t st;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic e_oob;
    logic ef_full;
    logic n_oob;
    logic nf_full;
    logic q_oob;
    logic el_oob;
    logic a_done;
    logic b_done;
    logic cnt_done;
    logic cnt_zero;
    logic emit_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/mnab_ctrl.sv @@
module mnab_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [1:0]     kind,
  input  mnab_pkg::sts_t sts,
  output mnab_pkg::cmd_t cmd,
  output logic           idle
);
  import mnab_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (kind_t'(kind))
            KIND_LINK:  state_next = S_L_RD;
            KIND_QUERY: state_next = S_Q_CHK;
            KIND_CLEAR: state_next = S_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_L_RD: state_next = S_L_CHK;
      S_L_CHK: begin
        if (sts.e_oob || sts.ef_full || sts.n_oob) state_next = S_PUSH;
        else state_next = S_L_NCHK;
      end
      S_L_NCHK: state_next = S_PUSH;
      S_PUSH: if (sts.out_free) state_next = S_IDLE;
      S_Q_CHK: begin
        if (sts.q_oob) state_next = S_PUSH;
        else state_next = S_Q_NF;
      end
      S_Q_NF: state_next = S_Q_A;
      S_Q_A: begin
        if (sts.a_done) state_next = S_Q_UNMARK;
        else state_next = S_Q_EL;
      end
      S_Q_EL: begin
        if (sts.el_oob) state_next = S_Q_A;
        else state_next = S_Q_EF;
      end
      S_Q_EF: state_next = S_Q_B;
      S_Q_B: begin
        if (sts.b_done) state_next = S_Q_A;
        else state_next = S_Q_ND;
      end
      S_Q_ND: state_next = S_Q_B;
      S_Q_UNMARK: state_next = S_Q_CNT;
      S_Q_CNT: if (sts.cnt_done) state_next = S_Q_CEND;
      S_Q_CEND: begin
        if (sts.cnt_zero) state_next = S_PUSH;
        else state_next = S_Q_EMIT;
      end
      S_Q_EMIT: if (sts.emit_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    cmd.ld_st = 1'b0;
    cmd.st = ST_OK;
    idle = 1'b0;
    unique case (state)
      S_CLEAR: cmd.op = OP_CLR;
      S_IDLE: idle = 1'b1;
      S_L_RD: cmd.op = OP_L_RD;
      S_L_CHK: begin
        if (sts.e_oob || sts.ef_full) begin
          cmd.ld_st = 1'b1;
          cmd.st = ST_ELEM_FULL;
        end else begin
          cmd.op = OP_L_WR_E;
          if (sts.n_oob) begin
            cmd.ld_st = 1'b1;
            cmd.st = ST_NODE_LIMIT;
          end
        end
      end
      S_L_NCHK: begin
        cmd.ld_st = 1'b1;
        if (sts.nf_full) begin
          cmd.st = ST_NODE_FULL;
        end else begin
          cmd.op = OP_L_WR_N;
          cmd.st = ST_OK;
        end
      end
      S_PUSH: if (sts.out_free) cmd.op = OP_PUSH;
      S_Q_CHK: begin
        if (sts.q_oob) begin
          cmd.ld_st = 1'b1;
          cmd.st = ST_Q_RANGE;
        end else begin
          cmd.op = OP_Q_MARK;
        end
      end
      S_Q_NF: cmd.op = OP_Q_NF;
      S_Q_A: if (!sts.a_done) cmd.op = OP_Q_RD_NEL;
      S_Q_EL: cmd.op = OP_Q_EL;
      S_Q_EF: cmd.op = OP_Q_EF;
      S_Q_B: if (!sts.b_done) cmd.op = OP_Q_RD_ENL;
      S_Q_ND: cmd.op = OP_Q_ND;
      S_Q_UNMARK: cmd.op = OP_Q_UNMARK;
      S_Q_CNT: cmd.op = OP_Q_CNT;
      S_Q_CEND: begin
        cmd.op = OP_Q_CEND;
        if (sts.cnt_zero) begin
          cmd.ld_st = 1'b1;
          cmd.st = ST_NO_NBR;
        end
      end
      S_Q_EMIT: cmd.op = OP_Q_EMIT;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/mnab_dp.sv @@
`include "mesh_node_adjacency_builder_macros.svh"

module mnab_dp #(
  parameter int MAX_NODES      = 4096,
  parameter int MAX_ELEMS      = 4096,
  parameter int NODES_PER_ELEM = 8,
  parameter int ELEMS_PER_NODE = 16,
  parameter int MAX_NEIGHBORS  = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  mnab_pkg::item_t                    item,
  input  logic                               cfg_we,
  input  logic [mnab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mnab_pkg::CFG_W-1:0]         cfg_data,
  input  mnab_pkg::cmd_t                     cmd,
  output mnab_pkg::sts_t                     sts,
  output logic                               result_valid,
  input  logic                               result_stall,
  output mnab_pkg::result_t                  result
);
  import mnab_pkg::*;

  localparam int EAW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int NAW = $clog2(MAX_NODES);
  localparam int CLR_DEPTH = (MAX_ELEMS > MAX_NODES) ? MAX_ELEMS : MAX_NODES;
  localparam int CAW = $clog2(CLR_DEPTH);
  localparam int EFW = $clog2(NODES_PER_ELEM + 1);
  localparam int NFW = $clog2(ELEMS_PER_NODE + 1);
  localparam int ENL_AW = $clog2(MAX_ELEMS * NODES_PER_ELEM);
  localparam int NEL_AW = $clog2(MAX_NODES * ELEMS_PER_NODE);
  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 2);
  localparam int EMT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_NEIGHBORS + 1);
  localparam logic [CNT_W-1:0] CNT_MAXN = CNT_W'(MAX_NEIGHBORS);

  // storage
  logic [EFW-1:0] efill_mem [MAX_ELEMS];
  logic [NFW-1:0] nfill_mem [MAX_NODES];
  logic           mark_mem  [MAX_NODES];
  logic [11:0]    enl_mem   [MAX_ELEMS * NODES_PER_ELEM];
  logic [11:0]    nel_mem   [MAX_NODES * ELEMS_PER_NODE];

  logic [CFG_W-1:0] node_limit, interior_limit;
  logic [LIM_W-1:0] nlim, ilim;
  logic [11:0] op_elem, op_node, el_q;
  logic [CAW-1:0] clr_addr;
  logic [NFW-1:0] a_idx, a_end;
  logic [EFW-1:0] b_idx, b_end;
  logic [LIM_W-1:0] j;
  logic [NAW-1:0] jq;
  logic rd_v;
  logic [CNT_W-1:0] count;
  logic [EMT_W-1:0] emitted;
  logic [2:0] pend_st;

  logic [EFW-1:0] efill_rd;
  logic [NFW-1:0] nfill_rd;
  logic           mark_rd;
  logic [11:0]    enl_rd, nel_rd;

  logic [EAW-1:0] efill_ra, efill_wa;
  logic [EFW-1:0] efill_wd;
  logic           efill_we;
  logic [NAW-1:0] nfill_wa;
  logic [NFW-1:0] nfill_wd;
  logic           nfill_we;
  logic [NAW-1:0] mark_ra, mark_wa;
  logic           mark_re, mark_we, mark_wd;
  logic [ENL_AW-1:0] enl_ra, enl_wa;
  logic [NEL_AW-1:0] nel_ra, nel_wa;

  logic hit, want_out, adv, emit_push, push, j_in, cnt_op, emit_op;
  logic [CNT_W-1:0] n_out;

  always_comb begin
    nlim = (LIM_W'(node_limit) > LIM_W'(MAX_NODES)) ? LIM_W'(MAX_NODES)
                                                    : LIM_W'(node_limit);
    ilim = (LIM_W'(interior_limit) > LIM_W'(MAX_NODES)) ? LIM_W'(MAX_NODES)
                                                        : LIM_W'(interior_limit);
  end

  assign cnt_op  = (cmd.op == OP_Q_CNT);
  assign emit_op = (cmd.op == OP_Q_EMIT);
  assign j_in    = (j < ilim);
  assign hit     = rd_v && mark_rd;
  assign want_out = hit && (emitted < EMT_W'(MAX_NEIGHBORS));
  assign adv     = !want_out || sts.out_free;
  assign emit_push = emit_op && want_out && sts.out_free;
  assign push    = (cmd.op == OP_PUSH) || emit_push;
  assign n_out   = (count > CNT_MAXN) ? CNT_MAXN : count;

  always_comb begin
    sts.clr_last  = (clr_addr == CAW'(CLR_DEPTH - 1));
    sts.e_oob     = (LIM_W'(op_elem) >= LIM_W'(MAX_ELEMS));
    sts.ef_full   = (efill_rd >= EFW'(NODES_PER_ELEM));
    sts.n_oob     = (LIM_W'(op_node) >= nlim);
    sts.nf_full   = (nfill_rd >= NFW'(ELEMS_PER_NODE));
    sts.q_oob     = (LIM_W'(op_node) >= ilim);
    sts.el_oob    = (LIM_W'(nel_rd) >= LIM_W'(MAX_ELEMS));
    sts.a_done    = (a_idx == a_end);
    sts.b_done    = (b_idx == b_end);
    sts.cnt_done  = !j_in && !rd_v;
    sts.cnt_zero  = (count == '0);
    sts.emit_done = !j_in && !rd_v;
    sts.out_free  = !result_valid || !result_stall;
  end

  // memory port steering
  always_comb begin
    efill_ra = (cmd.op == OP_Q_EL) ? EAW'(nel_rd) : EAW'(op_elem);
    efill_we = 1'b0;
    efill_wa = EAW'(op_elem);
    efill_wd = efill_rd + EFW'(1);
    nfill_we = 1'b0;
    nfill_wa = NAW'(op_node);
    nfill_wd = nfill_rd + NFW'(1);
    mark_re = 1'b0;
    mark_ra = NAW'(j[NAW-1:0]);
    mark_we = 1'b0;
    mark_wa = NAW'(op_node);
    mark_wd = 1'b0;
    enl_ra = ENL_AW'(el_q) * ENL_AW'(NODES_PER_ELEM) + ENL_AW'(b_idx);
    enl_wa = ENL_AW'(op_elem) * ENL_AW'(NODES_PER_ELEM) + ENL_AW'(efill_rd);
    nel_ra = NEL_AW'(op_node) * NEL_AW'(ELEMS_PER_NODE) + NEL_AW'(a_idx);
    nel_wa = NEL_AW'(op_node) * NEL_AW'(ELEMS_PER_NODE) + NEL_AW'(nfill_rd);
    unique case (cmd.op)
      OP_CLR: begin
        efill_we = (LIM_W'(clr_addr) < LIM_W'(MAX_ELEMS));
        efill_wa = EAW'(clr_addr);
        efill_wd = '0;
        nfill_we = (LIM_W'(clr_addr) < LIM_W'(MAX_NODES));
        nfill_wa = NAW'(clr_addr);
        nfill_wd = '0;
        mark_we = nfill_we;
        mark_wa = NAW'(clr_addr);
      end
      OP_L_WR_E: efill_we = 1'b1;
      OP_L_WR_N: nfill_we = 1'b1;
      OP_Q_MARK: begin
        mark_we = 1'b1;
        mark_wd = 1'b1;
      end
      OP_Q_ND: begin
        mark_we = (LIM_W'(enl_rd) < ilim);
        mark_wa = NAW'(enl_rd);
        mark_wd = 1'b1;
      end
      OP_Q_UNMARK: mark_we = 1'b1;
      OP_Q_CNT: mark_re = j_in;
      OP_Q_EMIT: begin
        mark_re = adv && j_in;
        mark_we = adv && hit;
        mark_wa = jq;
      end
      default: mark_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (efill_we) efill_mem[efill_wa] <= efill_wd;
    efill_rd <= efill_mem[efill_ra];
  end

  always_ff @(posedge clk) begin
    if (nfill_we) nfill_mem[nfill_wa] <= nfill_wd;
    nfill_rd <= nfill_mem[NAW'(op_node)];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (mark_re) mark_rd <= mark_mem[mark_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_L_WR_E) enl_mem[enl_wa] <= op_node;
    enl_rd <= enl_mem[enl_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_L_WR_N) nel_mem[nel_wa] <= op_elem;
    nel_rd <= nel_mem[nel_ra];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      node_limit <= LIMIT_RESET;
      interior_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_LIMIT:     node_limit <= cfg_data;
        REG_INTERIOR_LIMIT: interior_limit <= cfg_data;
        default:            node_limit <= node_limit;
      endcase
    end
  end

  // operand capture and walk counters
  always_ff @(posedge clk) begin
    if (accept) begin
      op_elem <= item.element;
      op_node <= item.node;
    end
    if (cmd.ld_st) pend_st <= cmd.st;
    unique case (cmd.op)
      OP_Q_NF: begin
        a_end <= (nfill_rd > NFW'(ELEMS_PER_NODE)) ? NFW'(ELEMS_PER_NODE) : nfill_rd;
        a_idx <= '0;
      end
      OP_Q_EL: begin
        el_q <= nel_rd;
        a_idx <= a_idx + NFW'(1);
      end
      OP_Q_EF: begin
        b_end <= (efill_rd > EFW'(NODES_PER_ELEM)) ? EFW'(NODES_PER_ELEM) : efill_rd;
        b_idx <= '0;
      end
      OP_Q_RD_ENL: b_idx <= b_idx + EFW'(1);
      default: el_q <= el_q;
    endcase
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (accept && (item.kind == KIND_CLEAR)) begin
      clr_addr <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_addr <= clr_addr + CAW'(1);
    end
  end

  // mark scan: count pass, then emit pass
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else if (cmd.op == OP_Q_UNMARK || cmd.op == OP_Q_CEND) begin
      rd_v <= 1'b0;
    end else if (cnt_op || (emit_op && adv)) begin
      rd_v <= j_in;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_Q_UNMARK: begin
        j <= '0;
        count <= '0;
      end
      OP_Q_CNT: begin
        if (hit && count != CNT_SAT) count <= count + CNT_W'(1);
        if (j_in) j <= j + LIM_W'(1);
      end
      OP_Q_CEND: begin
        j <= '0;
        emitted <= '0;
      end
      OP_Q_EMIT: begin
        if (adv) begin
          if (want_out) emitted <= emitted + EMT_W'(1);
          if (j_in) begin
            jq <= j[NAW-1:0];
            j <= j + LIM_W'(1);
          end
        end
      end
      default: jq <= jq;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_push) begin
      result.neighbor <= 12'(jq);
      result.last <= (CNT_W'(emitted) == n_out - CNT_W'(1));
      result.status <= (count > CNT_MAXN) ? ST_TRUNC : ST_OK;
    end else if (push) begin
      result.neighbor <= '0;
      result.last <= 1'b1;
      result.status <= pend_st;
    end
  end

  `MNAB_ASSERT_HOLDS(a_walk_elem_bound, cmd.op != OP_Q_RD_NEL || a_idx < a_end)
  `MNAB_ASSERT_HOLDS(a_emit_cap, !emit_push || (CNT_W'(emitted) < n_out))
  `MNAB_ASSERT_NEXT(a_count_start, cmd.op == OP_Q_UNMARK, count == '0 && !rd_v)

endmodule

@@ rtl/mesh_node_adjacency_builder.sv @@
// Mesh node adjacency builder.
// item channel (item_valid / item_stall / item): one transaction per item. kind link
//   stores an (element, node) pair, kind query asks for the neighbors of node, kind
//   clear empties the store. result channel (result_valid / result_stall / result)
//   returns one transaction per link or short query outcome, or one per neighbor in
//   ascending order with last set on the final one. Clear and unused kinds return none.
// cfg_we / cfg_index / cfg_data write node_limit (0) and interior_limit (1); write only
//   while the block is idle.
// Timing: items are taken one at a time; item_stall is low only in idle.
//   link: reads the fill counts (S_L_RD), checks the element and node limit (S_L_CHK),
//   then the node fill (S_L_NCHK) if both passed, and loads the result in S_PUSH.
//   query: marks the nodes of its incident elements, then scans the mark store up to
//   the effective interior limit twice, one node a cycle (count pass, then emit pass
//   that also clears the marks). Reset and clear: a sweep over max(MAX_ELEMS, MAX_NODES)
//   addresses zeroes the fill counts and marks; no item is taken meanwhile, config writes still land.
// A stalled result holds in the output register; the next item is still accepted,
//   and a query emit pass pauses on a neighbor until the register frees up.
module mesh_node_adjacency_builder #(
  parameter int MAX_NODES      = 4096,
  parameter int MAX_ELEMS      = 4096,
  parameter int NODES_PER_ELEM = 8,
  parameter int ELEMS_PER_NODE = 16,
  parameter int MAX_NEIGHBORS  = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  mnab_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output mnab_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [mnab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mnab_pkg::CFG_W-1:0]     cfg_data
);
  import mnab_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic accept;

  // item transaction completes only while the controller sits idle
  assign item_stall = !idle;
  assign accept = item_valid && idle;

  mnab_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (item.kind),
    .sts    (sts),
    .cmd    (cmd),
    .idle   (idle)
  );

  mnab_dp #(
    .MAX_NODES      (MAX_NODES),
    .MAX_ELEMS      (MAX_ELEMS),
    .NODES_PER_ELEM (NODES_PER_ELEM),
    .ELEMS_PER_NODE (ELEMS_PER_NODE),
    .MAX_NEIGHBORS  (MAX_NEIGHBORS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mnab_pkg::*;

  localparam int NODES    = 4096;
  localparam int ELEMS    = 4096;
  localparam int PER_ELEM = 8;
  localparam int PER_NODE = 16;
  localparam int NBR_MAX  = 64;
  // clear sweep covers max(ELEMS, NODES) addresses; give it margin before a config write
  localparam int SETTLE   = 4400;
  localparam int WDOG_MAX = 80000;

  typedef enum int {DO_ITEM, DO_DRAIN, DO_CFG} drv_kind_t;
  typedef struct {
    drv_kind_t         what;
    item_t             it;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]  data;
  } drv_entry_t;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  item_t                item;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mesh_node_adjacency_builder uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mesh store mirror
  logic [11:0] elem_nodes [ELEMS][PER_ELEM];
  int          elem_cnt   [ELEMS];
  logic [11:0] node_elems [NODES][PER_NODE];
  int          node_cnt   [NODES];
  bit          nbr_seen   [NODES];
  logic [CFG_W-1:0] node_lim_reg;
  logic [CFG_W-1:0] intr_lim_reg;

  drv_entry_t pending [$];
  result_t    expected_results [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  queries_sent = 0;
  int  cfg_writes = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  settle_cnt = 0;
  int  idle_cycles = 0;
  bit  quiet;

  assign quiet = pending.size() < 30;

  function automatic int eff_limit(logic [CFG_W-1:0] v);
    return (v > NODES) ? NODES : int'(v);
  endfunction

  function automatic status_t link_outcome(int e, int n);
    int ef;
    int nf;
    ef = elem_cnt[e];
    if (ef >= PER_ELEM) return ST_ELEM_FULL;
    elem_nodes[e][ef] = n[11:0];
    elem_cnt[e] = ef + 1;
    if (n >= eff_limit(node_lim_reg)) return ST_NODE_LIMIT;
    nf = node_cnt[n];
    if (nf >= PER_NODE) return ST_NODE_FULL;
    node_elems[n][nf] = e[11:0];
    node_cnt[n] = nf + 1;
    return ST_OK;
  endfunction

  // Appends the neighbor list of node i, or the short outcome, to the expectations.
  function automatic void predict_neighbors(int i);
    int lim;
    int el;
    int nd;
    logic [11:0] found [$];
    status_t st;
    lim = eff_limit(intr_lim_reg);
    if (i >= lim) begin
      expected_results.push_back('{12'd0, 1'b1, ST_Q_RANGE});
      return;
    end
    for (int a = 0; a < node_cnt[i]; a++) begin
      el = node_elems[i][a];
      for (int b = 0; b < elem_cnt[el]; b++) begin
        nd = elem_nodes[el][b];
        if (nd < lim) nbr_seen[nd] = 1;
      end
    end
    nbr_seen[i] = 0;
    for (int j = 0; j < lim; j++) begin
      if (nbr_seen[j]) begin
        nbr_seen[j] = 0;
        found.push_back(j[11:0]);
      end
    end
    if (found.size() == 0) begin
      expected_results.push_back('{12'd0, 1'b1, ST_NO_NBR});
      return;
    end
    st = (found.size() > NBR_MAX) ? ST_TRUNC : ST_OK;
    while (found.size() > NBR_MAX) void'(found.pop_back());
    foreach (found[k])
      expected_results.push_back('{found[k], (k == found.size() - 1), st});
  endfunction

  function automatic void predict_item(item_t it);
    case (kind_t'(it.kind))
      KIND_LINK: begin
        expected_results.push_back('{12'd0, 1'b1,
                                     link_outcome(int'(it.element), int'(it.node))});
      end
      KIND_QUERY: begin
        queries_sent++;
        predict_neighbors(int'(it.node));
      end
      KIND_CLEAR: begin
        for (int k = 0; k < ELEMS; k++) elem_cnt[k] = 0;
        for (int k = 0; k < NODES; k++) begin
          node_cnt[k] = 0;
          nbr_seen[k] = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void model_reset();
    for (int k = 0; k < ELEMS; k++) elem_cnt[k] = 0;
    for (int k = 0; k < NODES; k++) begin
      node_cnt[k] = 0;
      nbr_seen[k] = 0;
    end
    node_lim_reg = LIMIT_RESET;
    intr_lim_reg = LIMIT_RESET;
  endfunction

  task automatic add_item(kind_t k, int e, int n);
    drv_entry_t d;
    d.what = DO_ITEM;
    d.it = '{k, e[11:0], n[11:0]};
    d.idx = '0;
    d.data = '0;
    pending.push_back(d);
  endtask

  // drain everything, let the block settle, then write both limits
  task automatic add_cfg(int nl, int il);
    drv_entry_t d;
    d.it = '0;
    d.what = DO_DRAIN;
    d.idx = '0;
    d.data = '0;
    pending.push_back(d);
    d.what = DO_CFG;
    d.idx = REG_NODE_LIMIT;
    d.data = nl[CFG_W-1:0];
    pending.push_back(d);
    d.idx = REG_INTERIOR_LIMIT;
    d.data = il[CFG_W-1:0];
    pending.push_back(d);
  endtask

  // Random phase: mostly small element pools sharing a node window, some noise.
  task automatic add_random(int count, int win);
    int made;
    int ebase;
    int nbase;
    int e;
    int pick;
    made = 0;
    ebase = $urandom_range(0, ELEMS - 16);
    nbase = $urandom_range(0, 8);
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        e = ebase + $urandom_range(0, 15);
        repeat ($urandom_range(2, 6)) begin
          add_item(KIND_LINK, e, nbase + $urandom_range(0, win));
          made++;
        end
        if ($urandom_range(0, 2) == 0) begin
          add_item(KIND_QUERY, 0, nbase + $urandom_range(0, win));
          made++;
        end
      end else if (pick < 82) begin
        add_item(KIND_LINK, $urandom_range(0, 4095), $urandom_range(0, 4095));
        made++;
      end else if (pick < 92) begin
        add_item(KIND_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095));
        made++;
      end else if (pick < 97) begin
        add_item(KIND_NONE, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
        add_item(KIND_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
        made++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: one transaction at a time from the pending list; config writes only after
  // a drain step has seen every expected result and the settle time pass.
  always @(posedge clk) begin : driver
    logic                 nv;
    item_t                ni;
    logic                 we;
    logic [CFG_IDX_W-1:0] widx;
    logic [CFG_W-1:0]     wdat;
    nv = item_valid;
    ni = item;
    we = 1'b0;
    widx = cfg_index;
    wdat = cfg_data;
    if (rst) begin
      nv = 1'b0;
      ni = '0;
      widx = '0;
      wdat = '0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_item(item);
        items_sent++;
        nv = 1'b0;
      end
      if (!nv && pending.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (pending[0].what)
            DO_ITEM: begin
              ni = pending[0].it;
              nv = 1'b1;
              void'(pending.pop_front());
              if (!quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 3);
            end
            DO_DRAIN: begin
              if (expected_results.size() != 0 || result_valid) begin
                settle_cnt = 0;
              end else if (settle_cnt < SETTLE) begin
                settle_cnt++;
              end else begin
                settle_cnt = 0;
                void'(pending.pop_front());
              end
            end
            default: begin
              we = 1'b1;
              widx = pending[0].idx;
              wdat = pending[0].data;
              if (widx == REG_NODE_LIMIT) node_lim_reg = wdat;
              else intr_lim_reg = wdat;
              cfg_writes++;
              void'(pending.pop_front());
            end
          endcase
        end
      end
    end
    item_valid <= nv;
    item <= ni;
    cfg_we <= we;
    cfg_index <= widx;
    cfg_data <= wdat;
  end

  // Monitor: checks each result transaction against the oldest expectation and drives random result stalls.
  always @(posedge clk) begin : monitor
    result_t want;
    logic    st;
    if (rst) begin
      st = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: nbr=%0d last=%0b st=%0d",
                     result.neighbor, result.last, result.status);
        end else begin
          want = expected_results.pop_front();
          if (result.neighbor !== want.neighbor || result.last !== want.last ||
              result.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp nbr=%0d last=%0b st=%0d, got nbr=%0d last=%0b st=%0d",
                       want.neighbor, want.last, want.status,
                       result.neighbor, result.last, result.status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        st = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        st = 1'b1;
      end else begin
        st = 1'b0;
      end
    end
    result_stall <= st;
  end

  // Watchdog on cycles with no transaction and no config write.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    model_reset();

    // Directed: reset limits. Extremes of the fields, full element list, ignored kind.
    add_item(KIND_LINK, 0, 0);
    add_item(KIND_LINK, 4095, 4095);
    add_item(KIND_LINK, 4095, 0);
    add_item(KIND_QUERY, 0, 4095);
    add_item(KIND_QUERY, 0, 0);
    add_item(KIND_QUERY, 0, 1234);                 // no neighbors
    for (int k = 0; k < 8; k++) add_item(KIND_LINK, 7, 100 + k);
    add_item(KIND_LINK, 7, 200);                   // element list full
    add_item(KIND_QUERY, 0, 103);
    add_item(KIND_NONE, 4095, 4095);               // ignored
    add_item(KIND_CLEAR, 0, 0);
    add_item(KIND_QUERY, 0, 103);                  // empty after clear

    // Both limits zero: links lose the incidence entry, queries out of range.
    add_cfg(0, 0);
    add_item(KIND_LINK, 1, 5);
    add_item(KIND_QUERY, 0, 0);

    // All-ones limits clamp to the node count.
    add_cfg(8191, 8191);
    add_item(KIND_LINK, 2, 4095);
    add_item(KIND_LINK, 2, 3);
    add_item(KIND_QUERY, 0, 4095);

    // Node list full and neighbor truncation around hub node 5.
    add_cfg(96, 200);
    add_item(KIND_CLEAR, 0, 0);
    for (int e = 0; e < 17; e++) begin
      add_item(KIND_LINK, 300 + e, 5);
      if (e < 10)
        for (int k = 0; k < 7; k++) add_item(KIND_LINK, 300 + e, 6 + e * 7 + k);
    end
    add_item(KIND_LINK, 400, 150);                 // beyond node limit
    add_item(KIND_QUERY, 0, 5);
    add_item(KIND_QUERY, 0, 150);
    add_item(KIND_QUERY, 0, 250);

    add_cfg(4096, 128);
    add_item(KIND_CLEAR, 0, 0);
    add_random(20, 40);
    add_cfg($urandom_range(16, 64), $urandom_range(32, 96));
    add_random(20, 60);
    add_cfg($urandom_range(0, 8191), $urandom_range(16, 256));
    add_random(20, 30);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (expected_results.size() > 0) mismatches++;

    $display("Covered %0d items (%0d queries), %0d results, %0d limit writes.",
             items_sent, queries_sent, results_seen, cfg_writes);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
